>>> hdl/tgard_pkg.sv
package tgard_pkg;

    // Widths fixed by the stream and register map
    localparam int BYTE_W  = 8;
    localparam int FMT_W   = 2;
    localparam int CNT_W   = 25;
    localparam int CIDX_W  = 2;
    localparam int REP_W   = 8;

    // Default frame size limit
    localparam longint MAX_PIXELS_DEF = 64'd16777216;

    // Pixel formats
    localparam logic [FMT_W-1:0] FMT_GRAY = 2'd0;
    localparam logic [FMT_W-1:0] FMT_BGR  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_BGRA = 2'd2;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CIDX_W-1:0] REG_COUNT  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_RLE    = 2'd2;

    // Completed pixel from the byte assembler
    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] alpha;
    } pix_t;

endpackage

>>> hdl/tgard_pixel_asm.sv
module tgard_pixel_asm
    import tgard_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic              restart,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [FMT_W-1:0]  pixel_format,
    output pix_t              pix
);

    logic [1:0]        byte_index_reg, byte_index_next;
    logic [BYTE_W-1:0] color_reg [3];
    logic              last_byte;

    // Decide whether this byte closes the pixel
    always_comb begin
        unique case (pixel_format)
            FMT_GRAY: last_byte = 1'b1;
            FMT_BGR:  last_byte = (byte_index_reg >= 2'd2);
            default:  last_byte = (byte_index_reg == 2'd3);
        endcase
    end

    // Form the pixel colours
    always_comb begin
        pix.done = last_byte;
        unique case (pixel_format)
            FMT_GRAY: begin
                pix.blue  = data_byte;
                pix.green = data_byte;
                pix.red   = data_byte;
                pix.alpha = '0;
            end
            FMT_BGR: begin
                pix.blue  = color_reg[0];
                pix.green = color_reg[1];
                pix.red   = data_byte;
                pix.alpha = '0;
            end
            default: begin
                pix.blue  = color_reg[0];
                pix.green = color_reg[1];
                pix.red   = color_reg[2];
                pix.alpha = data_byte;
            end
        endcase
    end

    // Advance the byte position
    always_comb begin
        byte_index_next = byte_index_reg;
        if (restart) begin
            byte_index_next = '0;
        end else if (take) begin
            byte_index_next = last_byte ? 2'd0 : byte_index_reg + 2'd1;
        end
    end

    // Hold the position and the early colour bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= '0;
            color_reg[0]   <= '0;
            color_reg[1]   <= '0;
            color_reg[2]   <= '0;
        end else begin
            byte_index_reg <= byte_index_next;
            if (take && !last_byte && byte_index_reg != 2'd3) begin
                color_reg[byte_index_reg] <= data_byte;
            end
        end
    end

endmodule

>>> hdl/tga_rle_pixel_decoder.sv
// TGA run-length pixel decoder: one byte item in, at most one BGRA pixel item out.
// A pixel item is registered and offered in the cycle after its last byte is taken.
// Throughput: one byte per cycle, stalled while a full output register is not taken.
// Reset (aresetn low, synchronous): stream state cleared, header expected next,
// registers back to BGR, one pixel per frame, run-length packets on.
module tga_rle_pixel_decoder
    import tgard_pkg::*;
#(
    parameter longint MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_blue,
    output logic [BYTE_W-1:0] m_green,
    output logic [BYTE_W-1:0] m_red,
    output logic [BYTE_W-1:0] m_alpha,
    output logic [REP_W-1:0]  m_repeat_res,
    output logic              m_frame_end,
    output logic              m_overflow
);

    localparam int PIX_W = $clog2(MAX_PIXELS + 1);
    localparam int CW    = (PIX_W > CNT_W) ? PIX_W : CNT_W;
    localparam int RW    = (PIX_W > REP_W + 1) ? PIX_W : REP_W + 1;

    // Configuration registers
    logic [FMT_W-1:0] fmt_reg;
    logic [CNT_W-1:0] count_reg;
    logic             rle_reg;

    // Stream state
    logic             in_packet_reg, in_packet_next;
    logic             is_run_reg, is_run_next;
    logic [REP_W-1:0] left_reg, left_next;
    logic [PIX_W-1:0] done_reg, done_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] blue_reg, green_reg, red_reg, alpha_reg;
    logic [REP_W-1:0]  rep_reg;
    logic              fend_reg, ovf_reg;

    logic              acc, is_hdr, take, emit;
    pix_t              pix;
    logic [CW-1:0]     cnt_ext, cnt_nz, cnt_sat;
    logic [PIX_W-1:0]  cnt, remaining, done_raw;
    logic              done_lt;
    logic [REP_W-1:0]  want;
    logic [RW-1:0]     want_w, rem_w, rep_w;
    logic              fend, ovf;

    assign s_ready = !m_valid_reg || m_ready;
    assign acc     = s_valid && s_ready;
    assign is_hdr  = rle_reg && !in_packet_reg;
    assign take    = acc && !is_hdr;

    tgard_pixel_asm u_asm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .restart      (acc && is_hdr),
        .data_byte    (s_data_byte),
        .pixel_format (fmt_reg),
        .pix          (pix)
    );

    assign emit = take && pix.done;

    // Clamp the frame size
    always_comb begin
        cnt_ext = CW'(count_reg);
        cnt_nz  = (cnt_ext == '0) ? CW'(1) : cnt_ext;
        cnt_sat = (cnt_nz > CW'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : cnt_nz;
        cnt     = cnt_sat[PIX_W-1:0];
    end

    // Clip the repeat to the pixels left in the frame
    always_comb begin
        want      = (rle_reg && is_run_reg) ? left_reg : REP_W'(1);
        done_lt   = (done_reg < cnt);
        remaining = done_lt ? cnt - done_reg : PIX_W'(1);
        want_w    = RW'(want);
        rem_w     = RW'(remaining);
        rep_w     = (want_w < rem_w) ? want_w : rem_w;
        done_raw  = done_lt ? done_reg + PIX_W'(rep_w) : cnt;
        fend      = (done_raw >= cnt);
    end

    // Update packet and frame state
    always_comb begin
        in_packet_next = in_packet_reg;
        is_run_next    = is_run_reg;
        left_next      = left_reg;
        done_next      = done_reg;
        ovf            = 1'b0;
        if (acc && is_hdr) begin
            in_packet_next = 1'b1;
            is_run_next    = s_data_byte[BYTE_W-1];
            left_next      = s_data_byte[BYTE_W-1] ? s_data_byte - REP_W'(127)
                                                   : s_data_byte + REP_W'(1);
        end else if (emit) begin
            done_next = fend ? '0 : done_raw;
            if (rle_reg) begin
                left_next = (left_reg >= rep_w[REP_W-1:0]) ?
                            left_reg - rep_w[REP_W-1:0] : '0;
                if (left_next == '0) begin
                    in_packet_next = 1'b0;
                end else if (fend) begin
                    ovf            = 1'b1;
                    in_packet_next = 1'b0;
                    left_next      = '0;
                end
            end
        end
    end

    // Load or drain the output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg       <= FMT_BGR;
            count_reg     <= CNT_W'(1);
            rle_reg       <= 1'b1;
            in_packet_reg <= 1'b0;
            is_run_reg    <= 1'b0;
            left_reg      <= '0;
            done_reg      <= '0;
            m_valid_reg   <= 1'b0;
            fend_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FORMAT: fmt_reg   <= cfg_wdata[FMT_W-1:0];
                    REG_COUNT:  count_reg <= cfg_wdata;
                    REG_RLE:    rle_reg   <= cfg_wdata[0];
                    default:    ;
                endcase
            end
            in_packet_reg <= in_packet_next;
            is_run_reg    <= is_run_next;
            left_reg      <= left_next;
            done_reg      <= done_next;
            m_valid_reg   <= m_valid_next;
            if (emit) begin
                fend_reg <= fend;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            blue_reg  <= pix.blue;
            green_reg <= pix.green;
            red_reg   <= pix.red;
            alpha_reg <= pix.alpha;
            rep_reg   <= rep_w[REP_W-1:0];
            ovf_reg   <= ovf;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_blue       = blue_reg;
    assign m_green      = green_reg;
    assign m_red        = red_reg;
    assign m_alpha      = alpha_reg;
    assign m_repeat_res = rep_reg;
    assign m_frame_end  = fend_reg;
    assign m_overflow   = ovf_reg;

endmodule

>>> tb/sv/tga_rle_pixel_decoder_check.sv
module tga_rle_pixel_decoder_check
    import tgard_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [BYTE_W-1:0] m_blue,
    input  logic [BYTE_W-1:0] m_green,
    input  logic [BYTE_W-1:0] m_red,
    input  logic [BYTE_W-1:0] m_alpha,
    input  logic [REP_W-1:0]  m_repeat_res,
    input  logic              m_frame_end,
    input  logic              m_overflow,
    output int                fail_count,
    output int                outstanding,
    output int                pixels_seen,
    output int                frames_seen,
    output int                clipped_seen
);

    typedef struct {
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] alpha;
        logic [REP_W-1:0]  run_len;
        logic              frame_end;
        logic              overflow;
    } pixel_item_t;

    // Register copies
    logic [FMT_W-1:0]  fmt_q;
    logic [CNT_W-1:0]  count_q;
    logic              rle_q;

    // Stream state
    bit                in_pkt;
    bit                pkt_run;
    int unsigned       pkt_left;
    int unsigned       byte_pos;
    logic [BYTE_W-1:0] held [3];
    longint            done_px;

    pixel_item_t       expected_pixels [$];
    int                errs = 0;
    int                n_pixels = 0;
    int                n_frames = 0;
    int                n_clipped = 0;

    function automatic int unsigned bytes_per_px();
        if (fmt_q == FMT_GRAY) return 1;
        if (fmt_q == FMT_BGR) return 3;
        return 4;
    endfunction

    // Zero counts as one pixel, anything past the limit saturates
    function automatic longint frame_len();
        longint c;
        c = longint'(count_q);
        if (c == 0) c = 1;
        if (c > MAX_PIXELS_DEF) c = MAX_PIXELS_DEF;
        return c;
    endfunction

    // Add one byte to the pixel under assembly; fill the colours once it completes
    function automatic bit collect_byte(input logic [BYTE_W-1:0] b, output pixel_item_t px);
        int unsigned n;
        int unsigned i;
        n = bytes_per_px();
        i = byte_pos;
        if (i + 1 < n) begin
            held[i[1:0]] = b;
            byte_pos     = i + 1;
            return 1'b0;
        end
        byte_pos = 0;
        if (n == 1) begin
            px.blue  = b;
            px.green = b;
            px.red   = b;
            px.alpha = '0;
        end else if (n == 3) begin
            px.blue  = held[0];
            px.green = held[1];
            px.red   = b;
            px.alpha = '0;
        end else begin
            px.blue  = held[0];
            px.green = held[1];
            px.red   = held[2];
            px.alpha = b;
        end
        return 1'b1;
    endfunction

    // Advance the decoder by one byte; return 1 when a pixel item is due
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output pixel_item_t px);
        longint want;
        longint cnt;
        longint remaining;
        longint rep;
        if (!rle_q) begin
            if (!collect_byte(b, px)) return 1'b0;
            want = 1;
        end else if (!in_pkt) begin
            // header byte: open a raw packet or a run
            if (b < 8'd128) begin
                pkt_run  = 1'b0;
                pkt_left = b + 1;
            end else begin
                pkt_run  = 1'b1;
                pkt_left = b - 127;
            end
            in_pkt   = 1'b1;
            byte_pos = 0;
            return 1'b0;
        end else begin
            if (!collect_byte(b, px)) return 1'b0;
            want = pkt_run ? longint'(pkt_left) : 1;
        end

        cnt       = frame_len();
        remaining = (done_px < cnt) ? cnt - done_px : 1;
        rep       = (want < remaining) ? want : remaining;
        px.overflow  = 1'b0;
        px.frame_end = 1'b0;

        if (rle_q) begin
            pkt_left = (pkt_left >= rep) ? 32'(pkt_left - rep) : 0;
            if (pkt_left == 0) in_pkt = 1'b0;
        end

        if (done_px < cnt) done_px = done_px + rep;
        else done_px = cnt;

        // frame complete: clip whatever is left of the packet
        if (done_px >= cnt) begin
            px.frame_end = 1'b1;
            done_px      = 0;
            if (rle_q && in_pkt) begin
                px.overflow = 1'b1;
                in_pkt      = 1'b0;
                pkt_left    = 0;
            end
        end
        px.run_len = REP_W'(rep);
        return 1'b1;
    endfunction

    function automatic void match_field(input string name, input logic [7:0] want,
                                        input logic [7:0] seen);
        if (want !== seen) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
            errs++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        pixel_item_t px;
        if (!aresetn) begin
            fmt_q    = FMT_BGR;
            count_q  = 1;
            rle_q    = 1'b1;
            in_pkt   = 1'b0;
            pkt_run  = 1'b0;
            pkt_left = 0;
            byte_pos = 0;
            held[0]  = '0;
            held[1]  = '0;
            held[2]  = '0;
            done_px  = 0;
            expected_pixels.delete();
        end else begin
            // track register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FORMAT: fmt_q   = cfg_wdata[FMT_W-1:0];
                    REG_COUNT:  count_q = cfg_wdata;
                    REG_RLE:    rle_q   = cfg_wdata[0];
                    default:    ;
                endcase
            end

            // compare the pixel item taken at this edge with the oldest one due
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel item with none expected: blue %0d green %0d red %0d",
                           m_blue, m_green, m_red);
                    errs++;
                end else begin
                    px = expected_pixels.pop_front();
                    match_field("blue", px.blue, m_blue);
                    match_field("green", px.green, m_green);
                    match_field("red", px.red, m_red);
                    match_field("alpha", px.alpha, m_alpha);
                    match_field("repeat_res", px.run_len, m_repeat_res);
                    match_field("frame_end", 8'(px.frame_end), 8'(m_frame_end));
                    match_field("overflow", 8'(px.overflow), 8'(m_overflow));
                    n_pixels++;
                    if (px.frame_end) n_frames++;
                    if (px.overflow) n_clipped++;
                end
            end

            // predict from the byte item taken at this edge
            if (s_valid && s_ready) begin
                if (decode_byte(s_data_byte, px)) expected_pixels.push_back(px);
            end
        end
        fail_count   <= errs;
        outstanding  <= expected_pixels.size();
        pixels_seen  <= n_pixels;
        frames_seen  <= n_frames;
        clipped_seen <= n_clipped;
    end

endmodule

>>> tb/sv/tga_rle_pixel_decoder_test.sv
module tga_rle_pixel_decoder_test;
    import tgard_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int ITEM_TARGET = 1050;
    localparam int HOLD_PERIOD = 1500;
    localparam int HOLD_LEN    = 300;

    // Unused format code, decoded as four bytes
    localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [CIDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]  cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_data_byte;
    logic              m_valid;
    logic              m_ready;
    logic [BYTE_W-1:0] m_blue;
    logic [BYTE_W-1:0] m_green;
    logic [BYTE_W-1:0] m_red;
    logic [BYTE_W-1:0] m_alpha;
    logic [REP_W-1:0]  m_repeat_res;
    logic              m_frame_end;
    logic              m_overflow;

    int                fail_count;
    int                outstanding;
    int                pixels_seen;
    int                frames_seen;
    int                clipped_seen;

    int                bytes_sent;
    int                settings_used;
    int                burst_left;
    logic [FMT_W-1:0]  cur_fmt;
    logic              cur_rle;

    tga_rle_pixel_decoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_blue       (m_blue),
        .m_green      (m_green),
        .m_red        (m_red),
        .m_alpha      (m_alpha),
        .m_repeat_res (m_repeat_res),
        .m_frame_end  (m_frame_end),
        .m_overflow   (m_overflow)
    );

    tga_rle_pixel_decoder_check pixel_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_blue       (m_blue),
        .m_green      (m_green),
        .m_red        (m_red),
        .m_alpha      (m_alpha),
        .m_repeat_res (m_repeat_res),
        .m_frame_end  (m_frame_end),
        .m_overflow   (m_overflow),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .pixels_seen  (pixels_seen),
        .frames_seen  (frames_seen),
        .clipped_seen (clipped_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Offer one byte item; open a new burst after a random gap when the last one ran out
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                       : $urandom_range(1, 24);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        bytes_sent++;
    endtask

    // Drop valid and hold until every pixel item due has been taken
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [FMT_W-1:0] fmt, input logic [CNT_W-1:0] cnt,
                                 input logic rle);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FORMAT;
        cfg_wdata <= CNT_W'(fmt);
        @(posedge aclk);
        cfg_index <= REG_COUNT;
        cfg_wdata <= cnt;
        @(posedge aclk);
        cfg_index <= REG_RLE;
        cfg_wdata <= CNT_W'(rle);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_fmt = fmt;
        cur_rle = rle;
        settings_used++;
    endtask

    // Pixel bytes lean towards the extremes now and then
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One packet with random content, or a plain pixel, or a few stray bytes
    task automatic send_packet();
        int n;
        int pick;
        int bpp;
        bpp  = (cur_fmt == FMT_GRAY) ? 1 : (cur_fmt == FMT_BGR) ? 3 : 4;
        pick = $urandom_range(0, 99);
        if (!cur_rle) begin
            if (pick < 8) send_byte(pick_byte());
            else repeat (bpp) send_byte(pick_byte());
        end else if (pick < 45) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
            send_byte(8'(128 + n));
            repeat (bpp) send_byte(pick_byte());
        end else if (pick < 88) begin
            n = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
            send_byte(8'(n));
            repeat ((n + 1) * bpp) send_byte(pick_byte());
        end else begin
            // noise: stray bytes that cut packets short or shift the alignment
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
    endtask

    // Receiver: stall in segments of varying style, with a long hold-off now and then
    initial begin : receiver
        int span;
        int style;
        int cyc;
        m_ready <= 1'b0;
        cyc = 0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(10, 150);
            repeat (span) begin
                @(posedge aclk);
                cyc++;
                if (cyc % HOLD_PERIOD == HOLD_PERIOD / 2) begin
                    // hold off so the output register fills and the input backs up
                    m_ready <= 1'b0;
                    repeat (HOLD_LEN) @(posedge aclk);
                    cyc += HOLD_LEN;
                end else begin
                    case (style)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= 1'($urandom_range(0, 1));
                        2:       m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= (cyc % 5 != 0);
                    endcase
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("tga_rle_pixel_decoder_test: done, errors");
        $finish;
    end

    initial begin : stimulus
        logic [FMT_W-1:0] fmt;
        logic [CNT_W-1:0] cnt;
        logic             rle;
        int               budget;
        int               phase;

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_FORMAT;
        cfg_wdata   <= '0;
        s_valid     <= 1'b0;
        s_data_byte <= '0;
        bytes_sent    = 0;
        settings_used = 0;
        burst_left    = 0;
        cur_fmt       = FMT_BGR;
        cur_rle       = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Grey, zero count read as a one-pixel frame: raw pixel, then a full run clipped
        apply_setting(FMT_GRAY, '0, 1'b1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        settle();

        // Spare format code read as four bytes, single-copy run
        apply_setting(FMT_SPARE, CNT_W'(300), 1'b1);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();

        // Count lowered to the pixels already done: next run ends the frame clipped
        apply_setting(FMT_SPARE, CNT_W'(1), 1'b1);
        send_byte(8'h85);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'hFF);
        send_byte(8'h00);
        settle();

        // Uncompressed BGR with a saturating count; header-like bytes are plain data
        apply_setting(FMT_BGR, '1, 1'b0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(8'hFE);
        settle();

        // Uncompressed BGRA, one-pixel frame
        apply_setting(FMT_BGRA, CNT_W'(1), 1'b0);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h04);
        send_byte(8'h08);

        // Random phases, each under a fresh register setting
        phase = 0;
        while (bytes_sent < ITEM_TARGET) begin
            settle();
            fmt = ($urandom_range(0, 7) == 0) ? FMT_SPARE : FMT_W'($urandom_range(0, 2));
            case ($urandom_range(0, 11))
                0:       cnt = '0;
                1:       cnt = '1;
                2:       cnt = CNT_W'(MAX_PIXELS_DEF);
                3:       cnt = CNT_W'($urandom_range(1, 300));
                default: cnt = CNT_W'($urandom_range(1, 24));
            endcase
            if (phase == 0) cnt = CNT_W'(MAX_PIXELS_DEF);
            rle = ($urandom_range(0, 3) != 0);
            apply_setting(fmt, cnt, rle);
            budget = bytes_sent + $urandom_range(60, 160);
            while (bytes_sent < budget) send_packet();
            phase++;
        end
        settle();

        $display("covered %0d byte items under %0d register settings", bytes_sent,
                 settings_used);
        $display("checked %0d pixel items, %0d frame ends, %0d clipped packets",
                 pixels_seen, frames_seen, clipped_seen);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tga_rle_pixel_decoder_test: done, clean");
        end else begin
            $display("tga_rle_pixel_decoder_test: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/tgard_pkg.sv
hdl/tgard_pixel_asm.sv
hdl/tga_rle_pixel_decoder.sv
tb/sv/tga_rle_pixel_decoder_check.sv
tb/sv/tga_rle_pixel_decoder_test.sv
